// ===== rtl/pvsd_pkg.sv =====
// Package with constants and helper functions for the prefix varint signed decoder.
package pvsd_pkg;

    // Stream byte, decoded value and encoded length widths.
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 64;
    localparam int LEN_W   = 4;

    // Output tdata width: value and length packed, padded to whole bytes.
    localparam int M_DATA_W = ((VALUE_W + LEN_W + 7) / 8) * 8;

    // Length class of a 0xFF lead: a raw word with no sign extension.
    localparam logic [LEN_W-1:0] RAW_CLASS = 4'd8;

    // Classes at or above this one take no value bits from the lead byte.
    localparam logic [LEN_W-1:0] NO_LEAD_BITS_CLASS = 4'd7;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [LEN_W-1:0]   len_t;

    // Count of leading one bits in a byte, 0 to 8.
    function automatic len_t count_leading_ones(input logic [BYTE_W-1:0] b);
        len_t n;
        logic run;
        n   = '0;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            run = run & b[i];
            n   = n + {{(LEN_W-1){1'b0}}, run};
        end
        return n;
    endfunction

    // Sign-extend the gathered bits from 7 * (cls + 1) bits; the raw class passes as is.
    function automatic value_t sign_extend(input value_t acc, input len_t cls);
        value_t     result;
        logic [6:0] top;
        if (cls >= RAW_CLASS) begin
            result = acc;
        end else begin
            // Index of the sign bit: 7 * (cls + 1) - 1.
            top = 7'(({3'b000, cls} << 3) - {3'b000, cls} + 7'd6);
            for (int i = 0; i < VALUE_W; i++) begin
                result[i] = (7'(i) <= top) ? acc[i] : acc[top[5:0]];
            end
        end
        return result;
    endfunction

endpackage

// ===== rtl/prefix_varint_signed_decoder.sv =====
// Top level of the prefix varint signed decoder: byte stream in, decoded integers out.
//
// The block takes one stream byte per cycle on the slave side and keeps taking bytes every
// cycle while the master side is free or being drained. The count of leading ones in a lead
// byte gives how many bytes follow; the value bits are gathered big-endian and, on the last
// byte of an integer, sign-extended from 7 * (n + 1) bits (a 0xFF lead carries a raw 64-bit
// word). The result, with its encoded length of 1 to 9 bytes, appears on the master side
// in the cycle after its last byte is accepted, out of the result register that follows the
// combinational decode path. Bytes that finish no integer produce no beat. A partial integer
// stays pending until its remaining bytes arrive or until reset.
module prefix_varint_signed_decoder
    import pvsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata    // [63:0] value, [67:64] encoded_length, rest zero
);

    // Decoder state.
    len_t   bytes_left_reg, bytes_left_next;
    len_t   class_reg, class_next;
    value_t acc_reg, acc_next;

    // Result register.
    logic   m_valid_reg, m_valid_next;
    value_t m_value_reg, m_value_next;
    len_t   m_len_reg, m_len_next;

    logic   s_accept;
    logic   done;
    len_t   lead_ones;

    // A new byte may enter whenever the result register is empty or is being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Decode of one byte: prefix detection on a lead byte, shift-in otherwise.
    always_comb begin
        lead_ones       = count_leading_ones(s_tdata);
        bytes_left_next = bytes_left_reg;
        class_next      = class_reg;
        acc_next        = acc_reg;
        done            = 1'b0;
        if (bytes_left_reg == '0) begin
            class_next      = lead_ones;
            bytes_left_next = lead_ones;
            if (lead_ones >= NO_LEAD_BITS_CLASS) begin
                acc_next = '0;
            end else begin
                acc_next = {{(VALUE_W-BYTE_W){1'b0}}, s_tdata & (8'h7f >> lead_ones)};
            end
            done = (lead_ones == '0);
        end else begin
            acc_next        = {acc_reg[VALUE_W-BYTE_W-1:0], s_tdata};
            bytes_left_next = bytes_left_reg - len_t'(1);
            done            = (bytes_left_reg == len_t'(1));
        end
    end

    // Result register load and drain.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_len_next   = m_len_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept && done) begin
            m_valid_next = 1'b1;
            m_value_next = sign_extend(acc_next, class_next);
            m_len_next   = class_next + len_t'(1);
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            class_reg      <= '0;
            acc_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                bytes_left_reg <= bytes_left_next;
                class_reg      <= class_next;
                acc_reg        <= acc_next;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_len_reg   <= m_len_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-VALUE_W-LEN_W){1'b0}}, m_len_reg, m_value_reg};

endmodule
